### rtl/core/bspline_curve_evaluator_top_defines.svh
// Assertion macros for the B-spline curve evaluator.
`ifndef BSPLINE_CURVE_EVALUATOR_TOP_DEFINES_SVH
`define BSPLINE_CURVE_EVALUATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BCE_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) trig |=> prop) else $error(msg);
`else
`define BCE_ASSERT(lbl, prop, msg)
`define BCE_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

### rtl/core/bce_pkg.sv
// Package: types, constants and helpers for the B-spline curve evaluator.
`timescale 1ns / 1ps
package bce_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 7;

    localparam int ONE_Q16 = 65536;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // divider operand widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 18;

    // register indexes
    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;

    // item functions
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // result status
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_FEW = 1'b1;

    typedef struct packed {
        logic               func;
        logic [5:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] t_value;
    } bce_in_t;

    typedef struct packed {
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
        logic               status;
    } bce_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } cpoint_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    // floor of v / 2^30, saturated to 32-bit signed
    function automatic logic [31:0] sat_q30(input logic signed [63:0] v);
        logic signed [33:0] q;
        begin
            q = v[63:30];
            if (q > 34'sd2147483647) begin
                return 32'h7FFF_FFFF;
            end else if (q < -34'sd2147483648) begin
                return 32'h8000_0000;
            end else begin
                return q[31:0];
            end
        end
    endfunction

endpackage

### rtl/core/bce_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bce_div
    import bce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    output logic              busy,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   rem_sh;

    // shift in one dividend bit, subtract where it fits
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, quo_reg[DIV_NW-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = DIV_DW'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/bspline_curve_evaluator_top.sv
// Top level: clamped uniform B-spline evaluator with a shared multiplier and divider.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  input    | s_valid / s_ready           | s_data  (bce_in_t)
//  result   | m_valid / m_ready           | m_data  (bce_out_t)
//  config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A load item writes the point store and gives no result. An evaluate item runs
// the knot and recursion states and then the weighted sum of the points. One
// restoring divider serves both the knots and the recursion. Too few points
// skips to the done state, which registers a STATUS_FEW result. Reset is
// synchronous, active low; the point store is not cleared. A held result does
// not block loads; an evaluate waits at its end until the result register is free.
`timescale 1ns / 1ps
`include "bspline_curve_evaluator_top_defines.svh"
module bspline_curve_evaluator_top
    import bce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  bce_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output bce_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int IW = $clog2(MAX_POINTS + MAX_DEGREE + 1) + 1;
    localparam int DW = $clog2(MAX_DEGREE + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SPMUL = 5'd1;
    localparam logic [4:0] ST_SPAN  = 5'd2;
    localparam logic [4:0] ST_KL    = 5'd3;
    localparam logic [4:0] ST_KLW   = 5'd4;
    localparam logic [4:0] ST_KR    = 5'd5;
    localparam logic [4:0] ST_KRW   = 5'd6;
    localparam logic [4:0] ST_DEN   = 5'd7;
    localparam logic [4:0] ST_MA    = 5'd8;
    localparam logic [4:0] ST_DA    = 5'd9;
    localparam logic [4:0] ST_DAW   = 5'd10;
    localparam logic [4:0] ST_MB    = 5'd11;
    localparam logic [4:0] ST_DB    = 5'd12;
    localparam logic [4:0] ST_DBW   = 5'd13;
    localparam logic [4:0] ST_WR    = 5'd14;
    localparam logic [4:0] ST_RD    = 5'd15;
    localparam logic [4:0] ST_MX    = 5'd16;
    localparam logic [4:0] ST_MY    = 5'd17;
    localparam logic [4:0] ST_AY    = 5'd18;
    localparam logic [4:0] ST_DONE  = 5'd19;

    logic [4:0]         state_reg, state_next;
    logic [2:0]         deg_reg;
    logic [6:0]         cnt_reg;
    logic [16:0]        t_reg, t_next, t_clamp;
    logic [IW-1:0]      span_reg, span_next;
    logic [DW-1:0]      j_reg, j_next;
    logic [DW-1:0]      r_reg, r_next;
    logic [31:0]        saved_reg, saved_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic [16:0]        rr_reg, rr_next;
    logic [16:0]        ll_reg, ll_next;
    logic [17:0]        den_reg, den_next;
    logic               err_reg, err_next;
    logic signed [63:0] acc_x_reg, acc_x_next;
    logic signed [63:0] acc_y_reg, acc_y_next;
    logic               m_valid_reg, m_valid_next;
    bce_out_t           m_data_reg, m_data_next;
    logic signed [65:0] mul_reg;
    logic signed [32:0] mul_a, mul_b;

    logic [31:0]        w_reg   [MAX_DEGREE+1];
    logic [16:0]        lft_reg [MAX_DEGREE+1];
    logic [16:0]        rgt_reg [MAX_DEGREE+1];
    cpoint_t            mem     [MAX_POINTS];
    cpoint_t            rd_reg;

    logic [DW-1:0]      p_eff;
    logic [IW-1:0]      p_ext, n_eff, m_val, ki_l, ki_r, lim;
    logic               few;
    logic [65:0]        pm1;
    logic [49:0]        kk;
    logic               s_fire;

    div_req_t           div_req;
    logic               div_busy, div_done;
    logic [DIV_NW-1:0]  div_quo;

    // clamp configuration to the built store and array sizes
    always_comb begin
        if (32'(deg_reg) > MAX_DEGREE) begin
            p_eff = DW'(MAX_DEGREE);
        end else begin
            p_eff = DW'(deg_reg);
        end
        if (32'(cnt_reg) > MAX_POINTS) begin
            n_eff = IW'(MAX_POINTS);
        end else begin
            n_eff = IW'(cnt_reg);
        end
        p_ext = IW'(p_eff);
        m_val = n_eff - p_ext;
        few   = n_eff < p_ext + IW'(1);
        ki_l  = span_reg + IW'(1) - IW'(j_reg);
        ki_r  = span_reg + IW'(j_reg);
        lim   = n_eff - IW'(1) - p_ext;
        pm1   = mul_reg - 66'd1;
        kk    = pm1[65:16];
    end

    // clamp t to [0, 1.0]
    always_comb begin
        if (s_data.t_value < 0) begin
            t_clamp = '0;
        end else if (s_data.t_value > ONE_Q16) begin
            t_clamp = 17'(ONE_Q16);
        end else begin
            t_clamp = s_data.t_value[16:0];
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SPMUL: begin
                mul_a = $signed({16'b0, t_reg} + 33'd1);
                mul_b = $signed(33'(m_val));
            end
            ST_MA: begin
                mul_a = $signed({1'b0, w_reg[r_reg]});
                mul_b = $signed({16'b0, rr_reg});
            end
            ST_MB: begin
                mul_a = $signed({1'b0, w_reg[r_reg]});
                mul_b = $signed({16'b0, ll_reg});
            end
            ST_MX: begin
                mul_a = $signed({1'b0, w_reg[r_reg]});
                mul_b = {rd_reg.x[31], rd_reg.x};
            end
            ST_MY: begin
                mul_a = $signed({1'b0, w_reg[r_reg]});
                mul_b = {rd_reg.y[31], rd_reg.y};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        t_next       = t_reg;
        span_next    = span_reg;
        j_next       = j_reg;
        r_next       = r_reg;
        saved_next   = saved_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        rr_next      = rr_reg;
        ll_next      = ll_reg;
        den_next     = den_reg;
        err_next     = err_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_req      = '0;
        div_req.divisor  = DIV_DW'(m_val);
        div_req.dividend = DIV_NW'(ki_l - p_ext) << 16;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.func == FUNC_EVAL) begin
                    t_next     = t_clamp;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    err_next   = few;
                    state_next = few ? ST_DONE : ST_SPMUL;
                end
            end
            ST_SPMUL: begin
                state_next = ST_SPAN;
            end
            ST_SPAN: begin
                if (kk >= 50'(lim)) begin
                    span_next = n_eff - IW'(1);
                end else begin
                    span_next = p_ext + IW'(kk);
                end
                j_next     = DW'(1);
                r_next     = '0;
                state_next = (p_eff == '0) ? ST_RD : ST_KL;
            end
            ST_KL: begin
                if (ki_l <= p_ext) begin
                    state_next = ST_KR;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_KLW;
                end
            end
            ST_KLW: begin
                if (div_done) begin
                    state_next = ST_KR;
                end
            end
            ST_KR: begin
                div_req.dividend = DIV_NW'(ki_r - p_ext) << 16;
                r_next     = '0;
                saved_next = '0;
                if (ki_r >= n_eff) begin
                    state_next = ST_DEN;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_KRW;
                end
            end
            ST_KRW: begin
                if (div_done) begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                rr_next    = rgt_reg[DW'(r_reg + 1'b1)];
                ll_next    = lft_reg[DW'(j_reg - r_reg)];
                den_next   = {1'b0, rgt_reg[DW'(r_reg + 1'b1)]}
                           + {1'b0, lft_reg[DW'(j_reg - r_reg)]};
                state_next = ST_MA;
            end
            ST_MA: begin
                if (den_reg == '0) begin
                    a_next     = '0;
                    b_next     = '0;
                    state_next = ST_WR;
                end else begin
                    state_next = ST_DA;
                end
            end
            ST_DA: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_reg[DIV_NW-1:0];
                div_req.divisor  = den_reg;
                state_next       = ST_DAW;
            end
            ST_DAW: begin
                if (div_done) begin
                    a_next     = div_quo[31:0];
                    state_next = ST_MB;
                end
            end
            ST_MB: begin
                state_next = ST_DB;
            end
            ST_DB: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_reg[DIV_NW-1:0];
                div_req.divisor  = den_reg;
                state_next       = ST_DBW;
            end
            ST_DBW: begin
                if (div_done) begin
                    b_next     = div_quo[31:0];
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                if (r_reg == j_reg - 1'b1) begin
                    r_next = '0;
                    if (j_reg == p_eff) begin
                        state_next = ST_RD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_KL;
                    end
                end else begin
                    saved_next = b_reg;
                    r_next     = r_reg + 1'b1;
                    state_next = ST_DEN;
                end
            end
            ST_RD: begin
                state_next = ST_MX;
            end
            ST_MX: begin
                state_next = ST_MY;
            end
            ST_MY: begin
                acc_x_next = acc_x_reg + mul_reg[63:0];
                state_next = ST_AY;
            end
            ST_AY: begin
                acc_y_next = acc_y_reg + mul_reg[63:0];
                if (r_reg == p_eff) begin
                    state_next = ST_DONE;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_data_next.curve_x = '0;
                        m_data_next.curve_y = '0;
                        m_data_next.status  = STATUS_FEW;
                    end else begin
                        m_data_next.curve_x = sat_q30(acc_x_reg);
                        m_data_next.curve_y = sat_q30(acc_y_reg);
                        m_data_next.status  = STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            deg_reg     <= 3'd3;
            cnt_reg     <= 7'd4;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEGREE: deg_reg <= cfg_data[2:0];
                    REG_COUNT:  cnt_reg <= cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
        t_reg      <= t_next;
        span_reg   <= span_next;
        j_reg      <= j_next;
        r_reg      <= r_next;
        saved_reg  <= saved_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        rr_reg     <= rr_next;
        ll_reg     <= ll_next;
        den_reg    <= den_next;
        err_reg    <= err_next;
        acc_x_reg  <= acc_x_next;
        acc_y_reg  <= acc_y_next;
        m_data_reg <= m_data_next;
    end

    // basis weights and knot distances
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_SPAN: begin
                for (int k = 0; k <= MAX_DEGREE; k++) begin
                    w_reg[k] <= (k == 0) ? ONE_Q30 : 32'd0;
                end
            end
            ST_KL: begin
                if (ki_l <= p_ext) begin
                    lft_reg[j_reg] <= t_reg;
                end
            end
            ST_KLW: begin
                if (div_done) begin
                    lft_reg[j_reg] <= t_reg - div_quo[16:0];
                end
            end
            ST_KR: begin
                if (ki_r >= n_eff) begin
                    rgt_reg[j_reg] <= 17'(ONE_Q16) - t_reg;
                end
            end
            ST_KRW: begin
                if (div_done) begin
                    rgt_reg[j_reg] <= div_quo[16:0] - t_reg;
                end
            end
            ST_WR: begin
                w_reg[r_reg] <= saved_reg + a_reg;
                if (r_reg == j_reg - 1'b1) begin
                    w_reg[j_reg] <= b_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control point store: write on load items, registered read per term
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.func == FUNC_LOAD && 32'(s_data.point_index) < MAX_POINTS) begin
            mem[AW'(s_data.point_index)] <= {s_data.point_x, s_data.point_y};
        end
        if (state_reg == ST_RD) begin
            rd_reg <= mem[AW'(span_reg - p_ext + IW'(r_reg))];
        end
    end

    bce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BCE_ASSERT(a_span_range, state_reg == ST_KL |-> span_reg >= p_ext && span_reg < n_eff, "span out of range")
    `BCE_ASSERT(a_div_idle, div_req.start |-> !div_busy, "divider started while busy")
    `BCE_ASSERT(a_result_src, $rose(m_valid) |-> $past(state_reg == ST_DONE), "result without evaluate")
    `BCE_ASSERT_NEXT(a_div_run, state_reg == ST_DA, div_busy, "divider failed to start")

endmodule
